// ===== design/osps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osps_pkg
// shared types and constants of the odd-only segmented prime sieve
// ----------------------------------------------------------------------------
package osps_pkg;

    localparam int unsigned SIEVE_SPAN_DEF = 4096;
    localparam int unsigned PRIME_W        = 32;
    localparam int unsigned CFG_W          = 64;
    localparam int unsigned WORD_W         = 64;
    localparam int unsigned IDX_W          = 5;

    // register indexes
    localparam logic REG_RANGE_START = 1'b0;
    localparam logic REG_RANGE_END   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_FILL,
        S_MOD,
        S_START,
        S_MARK_RD,
        S_MARK_WR,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_ERR_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic setup;
        logic fill_step;
        logic mod_start;
        logic start_calc;
        logic mark_rd;
        logic mark_wr;
        logic emit_rd;
        logic emit_out;
        logic err_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic range_bad;
        logic first;
        logic last;
        logic skip;
        logic fill_done;
        logic mod_done;
        logic mark_done;
        logic emit_done;
        logic out_busy;
    } t_status;

endpackage

// ===== design/osps_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osps_in_if / osps_out_if
// valid/ready channels for prime items and bitmap words
// ----------------------------------------------------------------------------
interface osps_in_if;
    logic                               valid;
    logic                               ready;
    logic [osps_pkg::PRIME_W-1:0]       prime;
    logic                               first_item;
    logic                               last_item;
    modport source (output valid, prime, first_item, last_item, input ready);
    modport sink   (input valid, prime, first_item, last_item, output ready);
endinterface

interface osps_out_if;
    logic                               valid;
    logic                               ready;
    logic [osps_pkg::IDX_W-1:0]         word_index;
    logic [osps_pkg::WORD_W-1:0]        flag_word;
    logic                               last_word;
    logic                               range_error;
    modport source (output valid, word_index, flag_word, last_word, range_error,
                    input ready);
    modport sink   (input valid, word_index, flag_word, last_word, range_error,
                    output ready);
endinterface

// ===== design/osps_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osps_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module osps_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== design/osps_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osps_divider
// restoring remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
module osps_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_rem
);
    logic [63:0] r_dvd;
    logic [32:0] r_rem;
    logic [31:0] r_dvs;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [32:0] n_shift;
    logic [33:0] n_diff;

    // shift in next dividend bit and try subtract
    always_comb begin
        n_shift = {r_rem[31:0], r_dvd[63]};
        n_diff  = {1'b0, n_shift} - {2'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[62:0], 1'b0};
            r_rem <= n_diff[33] ? n_shift : n_diff[32:0];
        end
    end

    assign o_rem = r_rem[31:0];
endmodule

// ===== design/osps_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osps_datapath
// range registers, start offset arithmetic, bitmap ram and output register
// ----------------------------------------------------------------------------
module osps_datapath #(
    parameter int unsigned SIEVE_SPAN = osps_pkg::SIEVE_SPAN_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [63:0]           i_cfg_data,
    input  osps_pkg::t_cmd        i_cmd,
    output osps_pkg::t_status     o_status,
    osps_in_if.sink               in_ch,
    osps_out_if.source            out_ch
);
    localparam int unsigned FLAGS  = SIEVE_SPAN / 2;
    localparam int unsigned WORDS  = (FLAGS + 63) / 64;
    localparam int unsigned WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned FL_W   = $clog2(FLAGS) + 1;
    localparam int unsigned T_W    = 34;

    logic [63:0] r_cfg_a, r_cfg_b;
    logic [63:0] r_a, r_b;
    logic [31:0] r_p;
    logic        r_first, r_last, r_bad, r_skip;
    logic [FL_W-1:0] r_nflags;
    logic [WA_W:0]   r_nwords;
    logic [WA_W:0]   r_widx;
    logic [T_W-1:0]  r_t;
    logic [63:0]     r_pp;
    logic [63:0]     r_pm1sq;

    // range check
    logic [63:0] n_a, n_b, n_len;
    always_comb begin
        n_a   = r_cfg_a[0] ? r_cfg_a : r_cfg_a + 64'd1;
        n_b   = r_cfg_b[0] ? r_cfg_b : r_cfg_b - 64'd1;
        n_len = n_b - n_a + 64'd2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_a <= 64'd3;
            r_cfg_b <= 64'd3;
        end else if (i_cfg_we) begin
            if (i_cfg_index == osps_pkg::REG_RANGE_START) begin
                r_cfg_a <= i_cfg_data;
            end else begin
                r_cfg_b <= i_cfg_data;
            end
        end
    end

    // item capture and setup
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_p     <= in_ch.prime;
            r_first <= in_ch.first_item;
            r_last  <= in_ch.last_item;
            r_a     <= n_a;
            r_b     <= n_b;
            r_bad   <= (n_a < 64'd3) || (n_b < n_a) ||
                       (n_len > 64'(SIEVE_SPAN));
        end
        if (i_cmd.setup) begin
            r_nflags <= FL_W'(n_len[63:1]);
            r_nwords <= (WA_W+1)'((n_len[63:1] + 64'd63) >> 6);
            r_pp     <= {32'd0, r_p} * {32'd0, r_p};
            r_pm1sq  <= {32'd0, r_p - 32'd1} * {32'd0, r_p - 32'd1};
        end
    end

    // remainder ((a-p)/2) mod p
    logic        div_done;
    logic [31:0] div_rem;
    osps_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_start),
        .i_dividend ((r_a - {32'd0, r_p}) >> 1),
        .i_divisor  (r_p),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    logic [63:0] n_ppoff;
    logic [31:0] n_pr;
    always_comb begin
        n_ppoff = (r_pp - r_a) >> 1;
        n_pr    = r_p - div_rem;
    end

    // ram port
    logic [WA_W-1:0] ram_addr;
    logic            ram_we;
    logic [63:0]     ram_wdata, ram_rdata;
    logic [WA_W-1:0] r_fill;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_skip <= 1'b0;
        end else if (div_done) begin
            r_skip <= (r_p < 32'd3) || (r_pm1sq > r_b);
        end
        if (i_cmd.load_item) begin
            r_fill <= '0;
        end else if (i_cmd.fill_step) begin
            r_fill <= r_fill + WA_W'(1);
        end
        if (i_cmd.start_calc) begin
            if (r_pp >= r_a) begin
                r_t <= (n_ppoff > 64'(FLAGS)) ? T_W'(FLAGS) : T_W'(n_ppoff);
            end else begin
                r_t <= (n_pr == r_p) ? '0 : T_W'(n_pr);
            end
        end else if (i_cmd.mark_wr) begin
            r_t <= r_t + T_W'(r_p);
        end
        if (i_cmd.load_item) begin
            r_widx <= '0;
        end else if (i_cmd.emit_out) begin
            r_widx <= r_widx + 1'b1;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = ram_rdata;
        ram_addr  = r_t[6 +: WA_W];
        if (i_cmd.fill_step) begin
            ram_we    = 1'b1;
            ram_addr  = r_fill;
            ram_wdata = '1;
        end else if (i_cmd.mark_wr) begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~(64'd1 << r_t[5:0]);
        end else if (i_cmd.emit_rd) begin
            ram_addr = r_widx[WA_W-1:0];
        end
    end

    osps_ram #(.WIDTH(64), .DEPTH(WORDS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // output register
    logic [FL_W+6:0] n_rem;
    logic [63:0]     n_mask;
    always_comb begin
        n_rem  = (FL_W+7)'(r_nflags) - (FL_W+7)'({r_widx, 6'd0});
        n_mask = (n_rem >= (FL_W+7)'(64)) ? '1 : ((64'd1 << n_rem[5:0]) - 64'd1);
    end

    logic r_ovalid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit_out || i_cmd.err_out) begin
            r_ovalid <= 1'b1;
        end else if (out_ch.ready) begin
            r_ovalid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_out) begin
            out_ch.word_index  <= r_widx[osps_pkg::IDX_W-1:0];
            out_ch.flag_word   <= ram_rdata & n_mask;
            out_ch.last_word   <= (r_widx + 1'b1) == r_nwords;
            out_ch.range_error <= 1'b0;
        end else if (i_cmd.err_out) begin
            out_ch.word_index  <= '0;
            out_ch.flag_word   <= '0;
            out_ch.last_word   <= 1'b1;
            out_ch.range_error <= 1'b1;
        end
    end
    assign out_ch.valid = r_ovalid;

    always_comb begin
        o_status.range_bad = r_bad;
        o_status.first     = r_first;
        o_status.last      = r_last;
        o_status.skip      = r_skip;
        o_status.fill_done = r_fill == WA_W'(WORDS - 1);
        o_status.mod_done  = div_done;
        o_status.mark_done = r_t >= T_W'(r_nflags);
        o_status.emit_done = (r_widx + 1'b1) == r_nwords;
        o_status.out_busy  = r_ovalid && !out_ch.ready;
    end
endmodule

// ===== design/osps_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osps_ctrl
// sequencer for fill, start offset, marking walk and word emission
// ----------------------------------------------------------------------------
module osps_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  osps_pkg::t_status  i_status,
    output osps_pkg::t_cmd     o_cmd
);
    osps_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= osps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            osps_pkg::S_IDLE: begin
                if (i_in_valid) n_state = osps_pkg::S_SETUP;
            end
            osps_pkg::S_SETUP: begin
                if (i_status.range_bad) begin
                    n_state = i_status.last ? osps_pkg::S_ERR_OUT : osps_pkg::S_IDLE;
                end else if (i_status.first) begin
                    n_state = osps_pkg::S_FILL;
                end else begin
                    n_state = osps_pkg::S_MOD;
                end
            end
            osps_pkg::S_FILL: begin
                if (i_status.fill_done) n_state = osps_pkg::S_MOD;
            end
            osps_pkg::S_MOD: begin
                if (i_status.mod_done) n_state = osps_pkg::S_START;
            end
            osps_pkg::S_START: begin
                if (i_status.skip) begin
                    n_state = i_status.last ? osps_pkg::S_EMIT_RD : osps_pkg::S_IDLE;
                end else begin
                    n_state = osps_pkg::S_MARK_RD;
                end
            end
            osps_pkg::S_MARK_RD: begin
                if (i_status.mark_done) begin
                    n_state = i_status.last ? osps_pkg::S_EMIT_RD : osps_pkg::S_IDLE;
                end else begin
                    n_state = osps_pkg::S_MARK_WR;
                end
            end
            osps_pkg::S_MARK_WR:  n_state = osps_pkg::S_MARK_RD;
            osps_pkg::S_EMIT_RD: begin
                if (!i_status.out_busy) n_state = osps_pkg::S_EMIT_OUT;
            end
            osps_pkg::S_EMIT_OUT: begin
                n_state = i_status.emit_done ? osps_pkg::S_IDLE : osps_pkg::S_EMIT_RD;
            end
            osps_pkg::S_ERR_OUT: begin
                if (!i_status.out_busy) n_state = osps_pkg::S_IDLE;
            end
            default: n_state = osps_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            osps_pkg::S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            osps_pkg::S_SETUP:    o_cmd.setup      = 1'b1;
            osps_pkg::S_FILL:     o_cmd.fill_step  = 1'b1;
            osps_pkg::S_MOD:      o_cmd.mod_start  = 1'b0;
            osps_pkg::S_START:    o_cmd.start_calc = 1'b1;
            osps_pkg::S_MARK_RD:  o_cmd.mark_rd    = 1'b1;
            osps_pkg::S_MARK_WR:  o_cmd.mark_wr    = 1'b1;
            osps_pkg::S_EMIT_RD:  o_cmd.emit_rd    = 1'b1;
            osps_pkg::S_EMIT_OUT: o_cmd.emit_out   = 1'b1;
            osps_pkg::S_ERR_OUT:  o_cmd.err_out    = !i_status.out_busy;
            default: o_cmd = '0;
        endcase
        // kick the divider on entry to the remainder wait
        if (n_state == osps_pkg::S_MOD && r_state != osps_pkg::S_MOD) begin
            o_cmd.mod_start = 1'b1;
        end
    end
endmodule

// ===== design/odd_segmented_prime_sieve.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odd_segmented_prime_sieve
// odd-only segmented sieve of eratosthenes over a configured range
// ----------------------------------------------------------------------------
// One prime is taken at a time. An item is accepted, set up, waits on the
// bit-serial remainder unit and computes its start offset, then clears its
// flags in a read-modify-write walk over the single port bitmap ram (about
// span/(2p) flags); a first item fills the bitmap word by word after setup,
// and a last item then emits the bitmap as 64-bit words, each read and then
// output, holding while the receiver stalls. No clearing pass after reset:
// the bitmap is valid once a first item has been sieved.
module odd_segmented_prime_sieve #(
    parameter int unsigned SIEVE_SPAN = osps_pkg::SIEVE_SPAN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    osps_in_if.sink     in_ch,
    osps_out_if.source  out_ch
);
    osps_pkg::t_cmd    cmd;
    osps_pkg::t_status status;

    osps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    osps_datapath #(.SIEVE_SPAN(SIEVE_SPAN)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );
endmodule

// ===== design/osps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osps_checker
// port level checks of the sieve
// ----------------------------------------------------------------------------
module osps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_last,
    input logic        i_out_err,
    input logic [63:0] i_out_word,
    input logic [4:0]  i_out_idx
);
    // error word is all zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_err |-> i_out_word == 64'd0 && i_out_last &&
        i_out_idx == 5'd0)
        else $error("error word not clean");

    // no item is taken back to back
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item taken back to back");

    // output holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word))
        else $error("word dropped");
endmodule

bind odd_segmented_prime_sieve osps_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (in_ch.valid),
    .i_in_ready  (in_ch.ready),
    .i_out_valid (out_ch.valid),
    .i_out_ready (out_ch.ready),
    .i_out_last  (out_ch.last_word),
    .i_out_err   (out_ch.range_error),
    .i_out_word  (out_ch.flag_word),
    .i_out_idx   (out_ch.word_index)
);
